[src/wplru_pkg.sv]
package wplru_pkg;

    localparam int NUM_WAYS_DEF   = 16;
    localparam int NUM_SETS_DEF   = 2048;
    localparam int NUM_CORES_DEF  = 4;
    localparam int STAMP_BITS_DEF = 64;

    localparam int BOUND_W     = 5;
    localparam int NUM_BOUNDS  = 3;
    localparam int VALID_W     = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_ACCESS = 2'd2;

    localparam logic [1:0] REG_BOUNDARY_ONE   = 2'd0;
    localparam logic [1:0] REG_BOUNDARY_TWO   = 2'd1;
    localparam logic [1:0] REG_BOUNDARY_THREE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  core;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [15:0] valid_bits;
        logic        is_hit;
        logic        is_write;
    } in_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       partition_empty;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } lane_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } merge_ctl_t;

endpackage

[src/wplru_lane.sv]
module wplru_lane #(
    parameter int NUM_SETS   = wplru_pkg::NUM_SETS_DEF,
    parameter int ADDR_W     = 11,
    parameter int STAMP_BITS = wplru_pkg::STAMP_BITS_DEF
) (
    input  logic                  aclk,
    input  wplru_pkg::lane_ctl_t  ctl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [STAMP_BITS-1:0] wdata,
    output logic [STAMP_BITS-1:0] rdata
);

    logic [STAMP_BITS-1:0] mem [NUM_SETS];
    logic [STAMP_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/wplru_merge.sv]
module wplru_merge #(
    parameter int NUM_WAYS   = wplru_pkg::NUM_WAYS_DEF,
    parameter int STAMP_BITS = wplru_pkg::STAMP_BITS_DEF
) (
    input  logic                                 aclk,
    input  wplru_pkg::merge_ctl_t                ctl,
    input  logic [NUM_WAYS-1:0][STAMP_BITS-1:0]  lane_stamp,
    input  logic [NUM_WAYS-1:0]                  lane_elig,
    input  logic                                 set_ok,
    output logic [$clog2(NUM_WAYS)-1:0]          best_way
);

    localparam int LEVELS = $clog2(NUM_WAYS);
    localparam int WAY_W  = LEVELS;
    localparam int SLOTS  = 1 << LEVELS;
    localparam int HALF   = SLOTS / 2;

    logic [STAMP_BITS-1:0] stamp_reg [SLOTS];
    logic [STAMP_BITS-1:0] stamp_next [SLOTS];
    logic                  ok_reg [SLOTS];
    logic                  ok_next [SLOTS];
    logic [WAY_W-1:0]      way_reg [SLOTS];
    logic [WAY_W-1:0]      way_next [SLOTS];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            stamp_next[i] = stamp_reg[i];
            ok_next[i]    = ok_reg[i];
            way_next[i]   = way_reg[i];
        end
        if (ctl.load) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i < NUM_WAYS) begin
                    stamp_next[i] = set_ok ? lane_stamp[i] : '0;
                    ok_next[i]    = lane_elig[i];
                end else begin
                    stamp_next[i] = '0;
                    ok_next[i]    = 1'b0;
                end
                way_next[i] = WAY_W'(i);
            end
        end else if (ctl.step) begin
            for (int i = 0; i < HALF; i++) begin
                if (ok_reg[2*i+1] &&
                    (!ok_reg[2*i] || stamp_reg[2*i+1] < stamp_reg[2*i])) begin
                    stamp_next[i] = stamp_reg[2*i+1];
                    ok_next[i]    = 1'b1;
                    way_next[i]   = way_reg[2*i+1];
                end else begin
                    stamp_next[i] = stamp_reg[2*i];
                    ok_next[i]    = ok_reg[2*i];
                    way_next[i]   = way_reg[2*i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            stamp_reg[i] <= stamp_next[i];
            ok_reg[i]    <= ok_next[i];
            way_reg[i]   <= way_next[i];
        end
    end

    assign best_way = way_reg[0];

endmodule

[src/way_partitioned_lru_replacement_top.sv]
// Channel   | Ports                          | Moves
// ----------+--------------------------------+------------------------------------
// request   | s_valid s_ready s_data         | victim / fill / access transaction
// result    | m_valid m_ready m_data         | victim_way, partition_empty
// config    | psel penable pwrite paddr ...  | boundary_one/two/three at 0x0/0x4/0x8
//
// Fill, access update and unused operations are taken in ST_IDLE and may follow back to back.
// A victim request passes through one stamp row read and the merge load, then one pairwise
// min level per cycle in the shared merge tree, then the output register.
// After reset the stamp memory is cleared one set per cycle, all NUM_SETS sets,
// with s_ready low. A pending result stalls a finished victim search until m_ready.
module way_partitioned_lru_replacement_top #(
    parameter int NUM_WAYS   = wplru_pkg::NUM_WAYS_DEF,
    parameter int NUM_SETS   = wplru_pkg::NUM_SETS_DEF,
    parameter int NUM_CORES  = wplru_pkg::NUM_CORES_DEF,
    parameter int STAMP_BITS = wplru_pkg::STAMP_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wplru_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output wplru_pkg::out_t                   m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wplru_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wplru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wplru_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int LEVELS = $clog2(NUM_WAYS);
    localparam int WAY_W  = LEVELS;
    localparam int LVL_W  = $clog2(LEVELS) + 1;
    localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int BW     = wplru_pkg::BOUND_W;
    localparam int PW     = BW + 1;
    localparam int SPLIT  = NUM_WAYS / NUM_CORES;
    localparam logic [BW-1:0] BND1_RST = BW'(1 * SPLIT);
    localparam logic [BW-1:0] BND2_RST = BW'(2 * SPLIT);
    localparam logic [BW-1:0] BND3_RST = BW'(3 * SPLIT);

    wplru_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [LVL_W-1:0]      lvl_cnt_reg, lvl_cnt_next;
    logic [STAMP_BITS-1:0] cnt_reg, cnt_next;
    logic [BW-1:0]         bnd_reg [wplru_pkg::NUM_BOUNDS];
    logic                  empty_reg, inv_found_reg, set_ok_reg;
    logic [WAY_W-1:0]      inv_way_reg;
    logic [NUM_WAYS-1:0]   elig_reg;
    logic                  m_valid_reg, m_valid_next;
    wplru_pkg::out_t       m_data_reg, m_data_next;

    logic                  s_accept, victim_acc, do_stamp, out_free;
    logic                  clearing, out_load;
    logic [PW-1:0]         start_w, end_w;
    logic                  empty_c, inv_found_c, set_ok_c;
    logic [WAY_W-1:0]      inv_way_c;
    logic [NUM_WAYS-1:0]   elig_c, vld_c;
    logic                  cfg_wr;
    logic [ADDR_W-1:0]     mem_addr;
    logic [STAMP_BITS-1:0] mem_wdata;
    wplru_pkg::lane_ctl_t  lane_ctl [NUM_WAYS];
    wplru_pkg::merge_ctl_t merge_ctl;
    logic [NUM_WAYS-1:0][STAMP_BITS-1:0] lane_stamp;
    logic [WAY_W-1:0]      best_way;

    function automatic logic [PW-1:0] part_left(input logic [2:0] c,
                                                input logic [BW-1:0] b0,
                                                input logic [BW-1:0] b1,
                                                input logic [BW-1:0] b2);
        logic [BW-1:0] v;
        v = (c == 3'd1) ? b0 : ((c == 3'd2) ? b1 : b2);
        if (c == 3'd0) begin
            return '0;
        end
        if (32'(c) >= NUM_CORES || c > 3'd3) begin
            return PW'(NUM_WAYS);
        end
        if (32'(v) > NUM_WAYS) begin
            return PW'(NUM_WAYS);
        end
        return {1'b0, v};
    endfunction

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bnd_reg[0] <= BND1_RST;
            bnd_reg[1] <= BND2_RST;
            bnd_reg[2] <= BND3_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                wplru_pkg::REG_BOUNDARY_ONE:   bnd_reg[0] <= pwdata[BW-1:0];
                wplru_pkg::REG_BOUNDARY_TWO:   bnd_reg[1] <= pwdata[BW-1:0];
                wplru_pkg::REG_BOUNDARY_THREE: bnd_reg[2] <= pwdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wplru_pkg::REG_BOUNDARY_ONE:   prdata = {{(32-BW){1'b0}}, bnd_reg[0]};
            wplru_pkg::REG_BOUNDARY_TWO:   prdata = {{(32-BW){1'b0}}, bnd_reg[1]};
            wplru_pkg::REG_BOUNDARY_THREE: prdata = {{(32-BW){1'b0}}, bnd_reg[2]};
            default:                       prdata = '0;
        endcase
    end

    // request decode
    assign s_accept   = s_valid && s_ready;
    assign victim_acc = s_accept && (s_data.operation == wplru_pkg::OP_VICTIM);
    assign set_ok_c   = 32'(s_data.set_index) < NUM_SETS;
    assign do_stamp   = s_accept && set_ok_c && (32'(s_data.way_index) < NUM_WAYS) &&
                        ((s_data.operation == wplru_pkg::OP_FILL) ||
                         ((s_data.operation == wplru_pkg::OP_ACCESS) &&
                          s_data.is_hit && !s_data.is_write));

    assign start_w = part_left({1'b0, s_data.core}, bnd_reg[0], bnd_reg[1], bnd_reg[2]);
    assign end_w   = part_left(3'({1'b0, s_data.core}) + 3'd1,
                               bnd_reg[0], bnd_reg[1], bnd_reg[2]);
    assign empty_c = (32'(s_data.core) >= NUM_CORES) || (start_w >= end_w);

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            elig_c[w] = (PW'(w) >= start_w) && (PW'(w) < end_w);
            vld_c[w]  = (w < wplru_pkg::VALID_W) ? s_data.valid_bits[4'(w)] : 1'b1;
        end
    end

    always_comb begin
        inv_found_c = 1'b0;
        inv_way_c   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (elig_c[w] && !vld_c[w]) begin
                inv_found_c = 1'b1;
                inv_way_c   = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (victim_acc) begin
            empty_reg     <= empty_c;
            inv_found_reg <= inv_found_c;
            inv_way_reg   <= inv_way_c;
            elig_reg      <= elig_c;
            set_ok_reg    <= set_ok_c;
        end
    end

    // control
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        lvl_cnt_next = lvl_cnt_reg;
        unique case (state_reg)
            wplru_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(NUM_SETS - 1)) begin
                    state_next = wplru_pkg::ST_IDLE;
                end
            end
            wplru_pkg::ST_IDLE: begin
                if (victim_acc) begin
                    state_next = wplru_pkg::ST_LOAD;
                end
            end
            wplru_pkg::ST_LOAD: begin
                lvl_cnt_next = '0;
                state_next   = wplru_pkg::ST_REDUCE;
            end
            wplru_pkg::ST_REDUCE: begin
                lvl_cnt_next = lvl_cnt_reg + 1'b1;
                if (lvl_cnt_reg == LVL_W'(LEVELS - 1)) begin
                    state_next = wplru_pkg::ST_EMIT;
                end
            end
            wplru_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = wplru_pkg::ST_IDLE;
                end
            end
            default: state_next = wplru_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        clearing        = 1'b0;
        out_load        = 1'b0;
        merge_ctl.load  = 1'b0;
        merge_ctl.step  = 1'b0;
        unique case (state_reg)
            wplru_pkg::ST_CLEAR:  clearing = 1'b1;
            wplru_pkg::ST_IDLE:   s_ready = 1'b1;
            wplru_pkg::ST_LOAD:   merge_ctl.load = 1'b1;
            wplru_pkg::ST_REDUCE: merge_ctl.step = 1'b1;
            wplru_pkg::ST_EMIT:   out_load = out_free;
            default: ;
        endcase
    end

    assign mem_addr  = clearing ? clr_cnt_reg : ADDR_W'(s_data.set_index);
    assign mem_wdata = clearing ? '0 : cnt_reg;
    assign cnt_next  = do_stamp ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            lane_ctl[w].we = clearing ||
                             (do_stamp && (32'(s_data.way_index) == w));
            lane_ctl[w].re = victim_acc;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            if (empty_reg) begin
                m_data_next.victim_way      = '0;
                m_data_next.partition_empty = 1'b1;
            end else begin
                m_data_next.victim_way      = inv_found_reg ? 4'(inv_way_reg) : 4'(best_way);
                m_data_next.partition_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wplru_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            lvl_cnt_reg <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lvl_cnt_reg <= lvl_cnt_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stamp lanes and merge
    for (genvar g = 0; g < NUM_WAYS; g++) begin : g_lane
        wplru_lane #(
            .NUM_SETS   (NUM_SETS),
            .ADDR_W     (ADDR_W),
            .STAMP_BITS (STAMP_BITS)
        ) u_lane (
            .aclk  (aclk),
            .ctl   (lane_ctl[g]),
            .addr  (mem_addr),
            .wdata (mem_wdata),
            .rdata (lane_stamp[g])
        );
    end

    wplru_merge #(
        .NUM_WAYS   (NUM_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) u_merge (
        .aclk       (aclk),
        .ctl        (merge_ctl),
        .lane_stamp (lane_stamp),
        .lane_elig  (elig_reg),
        .set_ok     (set_ok_reg),
        .best_way   (best_way)
    );

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == wplru_pkg::ST_EMIT))
        else $error("result raised outside emit");

    a_counter_needs_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |-> $past(s_valid && s_ready))
        else $error("access counter moved without a transaction");

    a_empty_way_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.partition_empty) |-> (m_data_reg.victim_way == '0))
        else $error("empty partition with nonzero way");

    a_load_then_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wplru_pkg::ST_LOAD) |=> (state_reg == wplru_pkg::ST_REDUCE))
        else $error("merge load not followed by reduction");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !do_stamp && !victim_acc)
        else $error("transaction taken during clearing pass");

endmodule
